// ===== hdl/sparse_accumulation_table_top_macros.svh =====
// ---------------------------------------------------------------------------
// sparse_accumulation_table_top_macros.svh
// Assertion macros for the sparse accumulation table.
// ---------------------------------------------------------------------------
`ifndef SPARSE_ACCUMULATION_TABLE_TOP_MACROS_SVH
`define SPARSE_ACCUMULATION_TABLE_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, masked during reset.
`define SAT_ASSERT_IMP(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, sampled on clk, masked during reset.
`define SAT_ASSERT_NXT(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error("assertion failed");
`else
`define SAT_ASSERT_IMP(lbl, ant, cons)
`define SAT_ASSERT_NXT(lbl, ant, cons)
`endif

`endif

// ===== hdl/sat_pkg.sv =====
// ---------------------------------------------------------------------------
// sat_pkg
// Types and constants shared by the sparse accumulation table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sat_pkg;

    localparam int ENTRIES = 1024;
    localparam int ROWS    = 256;
    localparam int ROW_W   = $clog2(ROWS);
    localparam int KEY_W   = 2 * ROW_W;
    localparam int KEYS    = ROWS * ROWS;
    localparam int SLOT_W  = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_SUB    = 3'd1,
        OP_CLIQUE = 3'd2,
        OP_GET    = 3'd3,
        OP_READ   = 3'd4
    } op_t;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_ZERODIV = 2'd3;

    typedef struct packed {
        logic [2:0]         operation;
        logic [7:0]         row;
        logic [7:0]         col;
        logic signed [31:0] value;
        logic [7:0]         node_c;
        logic [7:0]         node_d;
        logic [2:0]         clique_size;
        logic [9:0]         slot;
        logic [30:0]        divisor;
    } in_t;

    typedef struct packed {
        logic [7:0]         out_row;
        logic [7:0]         out_col;
        logic signed [31:0] out_value;
        logic [1:0]         status;
        logic [10:0]        entry_count;
        logic [31:0]        zero_events;
    } out_t;

endpackage

// ===== hdl/sat_ram.sv =====
// ---------------------------------------------------------------------------
// sat_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/sparse_accumulation_table_top.sv =====
// ---------------------------------------------------------------------------
// sparse_accumulation_table_top
// Sparse integer matrix held as a table of keyed entries in block RAM.
// ---------------------------------------------------------------------------
// Usage:
//   Present a command on request and raise start; it is taken at a clock edge
//   where start is high and busy is low. busy stays high until the result has
//   been shown. The result is marked on result by done, which is high for exactly one cycle;
//   the receiver cannot stall it and must capture it in that cycle.
// Steps per transaction (start accepted to done):
//   add / subtract / get : index read; on a hit value read and write back (get: no write)
//   add of zero, unknown : straight to the result
//   increment clique     : up to 12 updates, one per off-diagonal pair, plus the
//                          four skipped diagonal steps for four nodes
//   read entry           : slot read, then the one-bit-a-cycle divider
// The key-to-slot index RAM has one read port, so updates are strictly one at
// a time and the next transaction starts only after done.
// Reset: control state clears at once, then a clearing pass walks the index
// RAM one key a cycle (all ROWS*ROWS = 65536 keys) with busy high.
// Entry key and value RAMs are never cleared; only slots below the fill count
// are read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sparse_accumulation_table_top_macros.svh"

module sparse_accumulation_table_top
    import sat_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  in_t  request,
    output logic done,
    output out_t result
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_PAIR,
        S_LOOK,
        S_IDX,
        S_VAL,
        S_RSLOT,
        S_RDATA,
        S_DIV,
        S_OUT
    } state_t;

    state_t             state_reg;
    in_t                cmd_reg;
    logic [KEY_W-1:0]   clr_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [31:0]        delta_reg;
    logic [SLOT_W-1:0]  hit_reg;
    logic [1:0]         pi_reg;
    logic [1:0]         pj_reg;
    logic [1:0]         nlast_reg;
    logic [1:0]         status_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [31:0]        zero_reg;
    logic [7:0]         orow_reg;
    logic [7:0]         ocol_reg;
    logic [31:0]        oval_reg;
    logic [31:0]        rem_reg;
    logic [31:0]        quo_reg;
    logic [4:0]         dcnt_reg;
    logic               neg_reg;
    logic               done_reg;
    out_t               result_reg;

    // RAM ports
    logic               idx_we;
    logic [KEY_W-1:0]   idx_waddr;
    logic [SLOT_W:0]    idx_wdata;
    logic [SLOT_W:0]    idx_rdata;
    logic               ent_we;
    logic [SLOT_W-1:0]  ent_waddr;
    logic [SLOT_W-1:0]  key_raddr;
    logic [KEY_W-1:0]   key_rdata;
    logic               val_we;
    logic [SLOT_W-1:0]  val_waddr;
    logic [31:0]        val_wdata;
    logic [SLOT_W-1:0]  val_raddr;
    logic [31:0]        val_rdata;

    logic               room;
    logic               last_pair;
    logic [1:0]         ni;
    logic [1:0]         nj;
    logic [31:0]        sum;
    logic [32:0]        trial;
    logic [31:0]        shifted;
    logic [31:0]        quo_next;
    logic [2:0]         size_c;

    function automatic logic [7:0] node_sel(input in_t c, input logic [1:0] i);
        logic [7:0] n;
        unique case (i)
            2'd0:    n = c.row;
            2'd1:    n = c.col;
            2'd2:    n = c.node_c;
            default: n = c.node_d;
        endcase
        return n;
    endfunction

    sat_ram #(.WIDTH(SLOT_W + 1), .DEPTH(KEYS)) u_idx_ram (
        .clk(clk), .we(idx_we), .waddr(idx_waddr), .wdata(idx_wdata),
        .raddr(key_reg), .rdata(idx_rdata)
    );

    sat_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
        .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(key_reg),
        .raddr(key_raddr), .rdata(key_rdata)
    );

    sat_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_val_ram (
        .clk(clk), .we(val_we), .waddr(val_waddr), .wdata(val_wdata),
        .raddr(val_raddr), .rdata(val_rdata)
    );

    assign room      = count_reg < CNT_W'(ENTRIES);
    assign last_pair = (pi_reg == nlast_reg) && (pj_reg == nlast_reg);
    assign ni        = (pj_reg == nlast_reg) ? pi_reg + 2'd1 : pi_reg;
    assign nj        = (pj_reg == nlast_reg) ? 2'd0 : pj_reg + 2'd1;
    assign sum       = val_rdata + delta_reg;
    assign shifted   = {rem_reg[30:0], quo_reg[31]};
    assign trial     = {1'b0, shifted} - {2'b00, cmd_reg.divisor};
    assign quo_next  = {quo_reg[30:0], ~trial[32]};
    assign size_c    = (request.clique_size < 3'd2) ? 3'd2 :
                       (request.clique_size > 3'd4) ? 3'd4 : request.clique_size;

    // RAM control: clear the index, insert new entries, write back sums
    always_comb
    begin
        idx_we    = 1'b0;
        idx_waddr = key_reg;
        idx_wdata = {1'b1, count_reg[SLOT_W-1:0]};
        ent_we    = 1'b0;
        ent_waddr = count_reg[SLOT_W-1:0];
        val_we    = 1'b0;
        val_waddr = count_reg[SLOT_W-1:0];
        val_wdata = delta_reg;
        key_raddr = cmd_reg.slot[SLOT_W-1:0];
        val_raddr = cmd_reg.slot[SLOT_W-1:0];
        unique case (state_reg)
            S_CLEAR:
            begin
                idx_we    = 1'b1;
                idx_waddr = clr_reg;
                idx_wdata = '0;
            end
            S_IDX:
            begin
                val_raddr = idx_rdata[SLOT_W-1:0];
                if (!idx_rdata[SLOT_W] && room && cmd_reg.operation != OP_GET)
                begin
                    idx_we = 1'b1;
                    ent_we = 1'b1;
                    val_we = 1'b1;
                end
            end
            S_VAL:
            begin
                val_waddr = hit_reg;
                val_wdata = sum;
                val_we    = (cmd_reg.operation != OP_GET);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            count_reg  <= '0;
            zero_reg   <= '0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == '1)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg    <= request;
                        key_reg    <= {request.row, request.col};
                        status_reg <= ST_OK;
                        orow_reg   <= '0;
                        ocol_reg   <= '0;
                        oval_reg   <= '0;
                        pi_reg     <= 2'd0;
                        pj_reg     <= 2'd0;
                        nlast_reg  <= 2'(size_c - 3'd1);
                        priority case (request.operation)
                            OP_ADD:
                            begin
                                delta_reg <= request.value;
                                state_reg <= (request.value == '0) ? S_OUT : S_LOOK;
                            end
                            OP_SUB:
                            begin
                                delta_reg <= 32'd0 - request.value;
                                state_reg <= S_LOOK;
                            end
                            OP_CLIQUE:
                            begin
                                delta_reg <= 32'd1;
                                state_reg <= S_PAIR;
                            end
                            OP_GET:
                            begin
                                state_reg <= S_LOOK;
                            end
                            OP_READ:
                            begin
                                if (CNT_W'(request.slot) >= count_reg)
                                begin
                                    status_reg <= ST_EMPTY;
                                    state_reg  <= S_OUT;
                                end
                                else
                                begin
                                    state_reg <= S_RSLOT;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_OUT;
                            end
                        endcase
                    end
                end
                S_PAIR:
                begin
                    // skip diagonal steps of the pair walk
                    if (pi_reg == pj_reg)
                    begin
                        if (last_pair)
                        begin
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            pi_reg <= ni;
                            pj_reg <= nj;
                        end
                    end
                    else
                    begin
                        key_reg   <= {node_sel(cmd_reg, pi_reg), node_sel(cmd_reg, pj_reg)};
                        state_reg <= S_LOOK;
                    end
                end
                S_LOOK:
                begin
                    state_reg <= S_IDX;
                end
                S_IDX:
                begin
                    hit_reg <= idx_rdata[SLOT_W-1:0];
                    if (idx_rdata[SLOT_W])
                    begin
                        state_reg <= S_VAL;
                    end
                    else
                    begin
                        if (cmd_reg.operation != OP_GET)
                        begin
                            if (room)
                            begin
                                count_reg <= count_reg + 1'b1;
                            end
                            else
                            begin
                                status_reg <= ST_FULL;
                            end
                        end
                        if (cmd_reg.operation == OP_CLIQUE && !last_pair)
                        begin
                            pi_reg    <= ni;
                            pj_reg    <= nj;
                            state_reg <= S_PAIR;
                        end
                        else
                        begin
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_VAL:
                begin
                    if (cmd_reg.operation == OP_GET)
                    begin
                        oval_reg <= val_rdata;
                    end
                    if (cmd_reg.operation == OP_SUB && sum == '0)
                    begin
                        zero_reg <= zero_reg + 1'b1;
                    end
                    if (cmd_reg.operation == OP_CLIQUE && !last_pair)
                    begin
                        pi_reg    <= ni;
                        pj_reg    <= nj;
                        state_reg <= S_PAIR;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_RSLOT:
                begin
                    state_reg <= S_RDATA;
                end
                S_RDATA:
                begin
                    orow_reg <= key_rdata[KEY_W-1:ROW_W];
                    ocol_reg <= key_rdata[ROW_W-1:0];
                    neg_reg  <= val_rdata[31];
                    quo_reg  <= val_rdata[31] ? 32'd0 - val_rdata : val_rdata;
                    rem_reg  <= '0;
                    dcnt_reg <= '0;
                    if (cmd_reg.divisor == '0)
                    begin
                        status_reg <= ST_ZERODIV;
                        state_reg  <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    // restoring divide, one quotient bit a cycle
                    rem_reg  <= trial[32] ? shifted : trial[31:0];
                    quo_reg  <= quo_next;
                    dcnt_reg <= dcnt_reg + 1'b1;
                    if (dcnt_reg == '1)
                    begin
                        oval_reg  <= neg_reg ? 32'd0 - quo_next : quo_next;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    done_reg               <= 1'b1;
                    result_reg.out_row     <= orow_reg;
                    result_reg.out_col     <= ocol_reg;
                    result_reg.out_value   <= oval_reg;
                    result_reg.status      <= status_reg;
                    result_reg.entry_count <= count_reg;
                    result_reg.zero_events <= zero_reg;
                    state_reg              <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // a result strobe lasts one cycle only
    `SAT_ASSERT_NXT(a_done_pulse, done_reg, !done_reg)
    // an accepted transaction holds busy on the next cycle
    `SAT_ASSERT_NXT(a_accept_busy, start && !busy, busy)
    // the fill count never passes the table size
    `SAT_ASSERT_IMP(a_count_max, done_reg, result_reg.entry_count <= CNT_W'(ENTRIES))

endmodule
